// ===== design/assert_macros.svh =====
// Assertion macros shared by the queue RTL.
// Active in simulation; compiled to nothing when SYNTH is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_AT(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

// ===== design/tsq_pkg.sv =====
// Shared types and codes for the two-stack queue.
// No dependencies; used by two_stack_queue.
package tsq_pkg;

  // Operation codes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // Status codes
  localparam logic [1:0] ST_ENQ   = 2'd0;
  localparam logic [1:0] ST_DEQ   = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  localparam int unsigned DATA_W = 32;

  typedef struct packed {
    logic                     operation;
    logic signed [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data_out;
    logic        [1:0]        status;
  } out_t;

endpackage

// ===== design/two_stack_queue.sv =====
// FIFO queue built from two stacks held in two synchronous memories.
// Depends on tsq_pkg, tsq_ram and assert_macros.svh.
//
// Usage:
//   in_valid/in_stall/in_data carry one operation per transaction: enqueue
//   in_data.value, or dequeue the oldest word. Every transaction gives exactly
//   one result transaction on out_valid/out_stall/out_data (data_out, status).
// Path from accept to result valid:
//   enqueue, full drop, empty dequeue: result registered in the cycle after acceptance.
//   dequeue with words in the output stack: output memory read, then result register.
//   dequeue with an empty output stack and n words in the intake stack:
//   the refill moves one word per cycle through the intake memory read port
//   and the output memory write port; the oldest word goes to the result register.
// Throughput: one enqueue per cycle while the receiver does not stall; a dequeue occupies the
//   block until its result is registered, and only then is the next transaction accepted.
// Results sit in an output register; a new transaction is accepted while the
//   register holds a result that is being taken in the same cycle. While the
//   receiver stalls with a result pending, in_stall stays high.
// Reset: both stacks come up empty; memory contents are not cleared.
`include "assert_macros.svh"

module two_stack_queue #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  tsq_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output tsq_pkg::out_t  out_data
);

  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(STACK_DEPTH);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_MOVE = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] in_cnt_r, in_cnt_nxt;
  logic [CNT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic [CNT_W-1:0] in_cnt_m1, out_cnt_m1;

  logic             out_vld_r, out_vld_nxt;
  tsq_pkg::out_t    out_data_r, out_data_nxt;
  logic             out_ld;

  logic             in_acc;

  logic                      iram_we, iram_re;
  logic [tsq_pkg::DATA_W-1:0] iram_rdata;
  logic                      oram_we, oram_re;
  logic [tsq_pkg::DATA_W-1:0] oram_rdata;

  assign in_cnt_m1  = in_cnt_r - CNT_ONE;
  assign out_cnt_m1 = out_cnt_r - CNT_ONE;

  // accept only when idle and the result register is free or draining
  assign in_stall = !((state_r == S_IDLE) && (!out_vld_r || !out_stall));
  assign in_acc   = in_valid && !in_stall;

  // intake stack: pushed by enqueue, popped by refill
  tsq_ram #(.DEPTH(STACK_DEPTH), .WIDTH(tsq_pkg::DATA_W)) u_intake (
    .clk     (clk),
    .wr_en   (iram_we),
    .wr_addr (in_cnt_r[IDX_W-1:0]),
    .wr_data (in_data.value),
    .rd_en   (iram_re),
    .rd_addr (in_cnt_m1[IDX_W-1:0]),
    .rd_data (iram_rdata)
  );

  // output stack: pushed by refill, popped by dequeue
  tsq_ram #(.DEPTH(STACK_DEPTH), .WIDTH(tsq_pkg::DATA_W)) u_output (
    .clk     (clk),
    .wr_en   (oram_we),
    .wr_addr (out_cnt_r[IDX_W-1:0]),
    .wr_data (iram_rdata),
    .rd_en   (oram_re),
    .rd_addr (out_cnt_m1[IDX_W-1:0]),
    .rd_data (oram_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    in_cnt_nxt   = in_cnt_r;
    out_cnt_nxt  = out_cnt_r;
    iram_we      = 1'b0;
    iram_re      = 1'b0;
    oram_we      = 1'b0;
    oram_re      = 1'b0;
    out_ld       = 1'b0;
    out_data_nxt = out_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data.operation == tsq_pkg::OP_ENQ) begin
            out_ld                = 1'b1;
            out_data_nxt.data_out = '0;
            if (in_cnt_r == CNT_FULL) begin
              out_data_nxt.status = tsq_pkg::ST_FULL;
            end else begin
              iram_we             = 1'b1;
              in_cnt_nxt          = in_cnt_r + CNT_ONE;
              out_data_nxt.status = tsq_pkg::ST_ENQ;
            end
          end else if (out_cnt_r != '0) begin
            // pop straight from the output stack
            oram_re     = 1'b1;
            out_cnt_nxt = out_cnt_m1;
            state_nxt   = S_POP;
          end else if (in_cnt_r != '0) begin
            // start the refill with the intake top
            iram_re    = 1'b1;
            in_cnt_nxt = in_cnt_m1;
            state_nxt  = S_MOVE;
          end else begin
            out_ld                = 1'b1;
            out_data_nxt.data_out = '0;
            out_data_nxt.status   = tsq_pkg::ST_EMPTY;
          end
        end
      end
      S_POP: begin
        out_ld                = 1'b1;
        out_data_nxt.data_out = oram_rdata;
        out_data_nxt.status   = tsq_pkg::ST_DEQ;
        state_nxt             = S_IDLE;
      end
      S_MOVE: begin
        if (in_cnt_r == '0) begin
          // last word read is the oldest one: hand it out, no write-back
          out_ld                = 1'b1;
          out_data_nxt.data_out = iram_rdata;
          out_data_nxt.status   = tsq_pkg::ST_DEQ;
          state_nxt             = S_IDLE;
        end else begin
          oram_we     = 1'b1;
          out_cnt_nxt = out_cnt_r + CNT_ONE;
          iram_re     = 1'b1;
          in_cnt_nxt  = in_cnt_m1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result register valid
  always_comb begin
    if (out_ld) begin
      out_vld_nxt = 1'b1;
    end else begin
      out_vld_nxt = out_vld_r && out_stall;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      in_cnt_r  <= '0;
      out_cnt_r <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      in_cnt_r  <= in_cnt_nxt;
      out_cnt_r <= out_cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // checks
  `ASSERT_AT(a_cnt_range, clk, rst_n, (in_cnt_r <= CNT_FULL) && (out_cnt_r <= CNT_FULL), "stack count beyond depth")
  `ASSERT_AT(a_move_fits, clk, rst_n, (state_r == S_MOVE) |-> (out_cnt_r < CNT_FULL), "refill overflows output stack")
  `ASSERT_NEVER(a_no_clobber, clk, rst_n, out_ld && out_vld_r && out_stall, "pending result overwritten")
  `ASSERT_AT(a_pop_cause, clk, rst_n, (state_r == S_POP) |-> $past(in_acc && (in_data.operation == tsq_pkg::OP_DEQ)), "pop without dequeue")

endmodule

// ===== design/tsq_ram.sv =====
// Simple dual-port stack memory: one write port, one read port, registered read data.
// No package dependencies.
module tsq_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
